FILE: sv/imu_fifo_frame_decoder_assert.svh
// Assertion macros used by the checker file of the frame decoder.
`ifndef IMU_FIFO_FRAME_DECODER_ASSERT_SVH
`define IMU_FIFO_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, silenced while reset is asserted.
`define IMU_FFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, silenced while reset is asserted.
`define IMU_FFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/imu_ffd_pkg.sv
package imu_ffd_pkg;

    localparam int RAW_W    = 16;
    localparam int SCALED_W = RAW_W + 3;
    localparam int OUT_W    = 20;
    localparam int FACTOR_W = 7;
    localparam int PROD_W   = SCALED_W + FACTOR_W;
    localparam int SHIFT    = 9;
    localparam int ACC_W    = SCALED_W + SHIFT + 1;
    localparam int IN_W     = 6 * RAW_W;
    localparam int OUT_DW   = 6 * OUT_W;

    localparam logic [RAW_W-1:0] OVERREAD_WORD    = 16'h8000;
    localparam logic [RAW_W-1:0] INV_ACCEL_X_WORD = 16'h7F01;
    localparam logic [RAW_W-1:0] INV_GYRO_X_WORD  = 16'h7F02;
    localparam logic [RAW_W-1:0] INV_YZ_WORD      = 16'h8000;

    typedef enum logic [1:0] {
        CFG_ACCEL_RANGE  = 2'd0,
        CFG_GYRO_RANGE   = 2'd1,
        CFG_CROSS_FACTOR = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]                 accel_range_sel;
        logic [1:0]                 gyro_range_sel;
        logic signed [FACTOR_W-1:0] cross_axis_factor;
    } t_cfg;

    // frame_skipped sits in the lowest bit
    typedef struct packed {
        logic gyro_fresh;
        logic accel_fresh;
        logic frame_skipped;
    } t_flags;

    // x sits in the lowest bits
    typedef struct packed {
        logic signed [OUT_W-1:0] z;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] x;
    } t_vec3;

    // Sign-extend a raw word and scale it by the range shift.
    function automatic logic signed [SCALED_W-1:0] scale_word(
        input logic [RAW_W-1:0] raw,
        input logic [1:0]       sel
    );
        logic signed [SCALED_W-1:0] ext;
        ext = SCALED_W'(signed'(raw));
        return ext <<< sel;
    endfunction

endpackage

FILE: sv/imu_ffd_decode.sv
module imu_ffd_decode (
    input  logic [imu_ffd_pkg::IN_W-1:0] i_frame,
    input  imu_ffd_pkg::t_cfg            i_cfg,
    input  imu_ffd_pkg::t_vec3           i_held_accel,
    input  imu_ffd_pkg::t_vec3           i_held_gyro,
    output imu_ffd_pkg::t_flags          o_flags,
    output imu_ffd_pkg::t_vec3           o_accel,
    output imu_ffd_pkg::t_vec3           o_gyro
);

    localparam int RW = imu_ffd_pkg::RAW_W;
    localparam int SW = imu_ffd_pkg::SCALED_W;
    localparam int OW = imu_ffd_pkg::OUT_W;
    localparam int PW = imu_ffd_pkg::PROD_W;
    localparam int AW = imu_ffd_pkg::ACC_W;
    localparam int SH = imu_ffd_pkg::SHIFT;

    logic [RW-1:0] w_gx, w_gy, w_gz, w_ax, w_ay, w_az;
    logic          w_skip, w_accel_ok, w_gyro_ok;
    logic signed [SW-1:0] w_axs, w_ays, w_azs, w_gxs, w_gys, w_gzs;
    logic signed [OW-1:0] w_ay_ext, w_gy_ext;
    logic signed [PW-1:0] w_prod;
    logic signed [AW-1:0] w_acc;

    assign w_gx = i_frame[0*RW +: RW];
    assign w_gy = i_frame[1*RW +: RW];
    assign w_gz = i_frame[2*RW +: RW];
    assign w_ax = i_frame[3*RW +: RW];
    assign w_ay = i_frame[4*RW +: RW];
    assign w_az = i_frame[5*RW +: RW];

    assign w_skip     = (w_gx == imu_ffd_pkg::OVERREAD_WORD);
    assign w_accel_ok = !((w_ax == imu_ffd_pkg::INV_ACCEL_X_WORD) &&
                          (w_ay == imu_ffd_pkg::INV_YZ_WORD) &&
                          (w_az == imu_ffd_pkg::INV_YZ_WORD));
    assign w_gyro_ok  = !((w_gx == imu_ffd_pkg::INV_GYRO_X_WORD) &&
                          (w_gy == imu_ffd_pkg::INV_YZ_WORD) &&
                          (w_gz == imu_ffd_pkg::INV_YZ_WORD));

    assign w_axs = imu_ffd_pkg::scale_word(w_ax, i_cfg.accel_range_sel);
    assign w_ays = imu_ffd_pkg::scale_word(w_ay, i_cfg.accel_range_sel);
    assign w_azs = imu_ffd_pkg::scale_word(w_az, i_cfg.accel_range_sel);
    assign w_gxs = imu_ffd_pkg::scale_word(w_gx, i_cfg.gyro_range_sel);
    assign w_gys = imu_ffd_pkg::scale_word(w_gy, i_cfg.gyro_range_sel);
    assign w_gzs = imu_ffd_pkg::scale_word(w_gz, i_cfg.gyro_range_sel);

    // widen before negating so that full-scale negative stays in range
    assign w_ay_ext = OW'(w_ays);
    assign w_gy_ext = OW'(w_gys);

    // x*512 - z*factor, then floor by arithmetic shift
    assign w_prod = PW'(w_gzs) * PW'(i_cfg.cross_axis_factor);
    assign w_acc  = (AW'(w_gxs) <<< SH) - AW'(w_prod);

    always_comb begin
        o_flags.frame_skipped = w_skip;
        o_flags.accel_fresh   = !w_skip && w_accel_ok;
        o_flags.gyro_fresh    = !w_skip && w_gyro_ok;

        o_accel = i_held_accel;
        if (o_flags.accel_fresh) begin
            o_accel.x = -w_ay_ext;
            o_accel.y = OW'(w_axs);
            o_accel.z = OW'(w_azs);
        end

        o_gyro = i_held_gyro;
        if (o_flags.gyro_fresh) begin
            o_gyro.x = -w_gy_ext;
            o_gyro.y = w_acc[AW-1:SH];
            o_gyro.z = OW'(w_gzs);
        end
    end

endmodule

FILE: sv/imu_fifo_frame_decoder.sv
// Decodes one 12-byte inertial sensor FIFO frame per transfer: six raw
// 16-bit words (gyro x/y/z, accel x/y/z) in, held and remapped accel and
// gyro vectors out, with flags saying whether the frame was an overread
// (skipped) and which sections were fresh. Invalid sections and skipped
// frames leave the held values as they were; reset clears them to zero.
// Accel is in units of 1/16384 g, gyro in 250/32768 dps, each scaled by
// its range select; gyro y out is the cross-axis corrected raw x.
// Throughput is one frame per clock unless the output stalls; the input
// register and the result register lie between the input transfer and the
// result, around the single 19x7 cross-axis multiply. The result
// register doubles as the held store, so a stalled result only blocks the
// input once the input register is also full. Write the configuration
// registers only while no frame is in flight; o_cfg_ready is always high.
module imu_fifo_frame_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [imu_ffd_pkg::FACTOR_W-1:0]  i_cfg_data,
    // frame in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // gyro_x_raw, gyro_y_raw, gyro_z_raw, accel_x_raw, accel_y_raw,
    // accel_z_raw (16 bits each, lowest first)
    input  logic [imu_ffd_pkg::IN_W-1:0]      s_axis_tdata,
    // decoded result out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // accel_out_x, accel_out_y, accel_out_z, gyro_out_x, gyro_out_y,
    // gyro_out_z (20 bits signed each, lowest first)
    output logic [imu_ffd_pkg::OUT_DW-1:0]    m_axis_tdata,
    // frame_skipped, accel_fresh, gyro_fresh (lowest first)
    output logic [2:0]                        m_axis_tuser
);

    imu_ffd_pkg::t_cfg   r_cfg;
    logic                r_in_valid;
    logic [imu_ffd_pkg::IN_W-1:0] r_in_data;
    logic                r_out_valid;
    imu_ffd_pkg::t_flags r_flags;
    imu_ffd_pkg::t_vec3  r_accel;
    imu_ffd_pkg::t_vec3  r_gyro;

    imu_ffd_pkg::t_flags n_flags;
    imu_ffd_pkg::t_vec3  n_accel;
    imu_ffd_pkg::t_vec3  n_gyro;

    logic w_advance;
    logic w_in_xfer;

    // Advance the result register when it is empty or being drained.
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    imu_ffd_decode u_decode (
        .i_frame      (r_in_data),
        .i_cfg        (r_cfg),
        .i_held_accel (r_accel),
        .i_held_gyro  (r_gyro),
        .o_flags      (n_flags),
        .o_accel      (n_accel),
        .o_gyro       (n_gyro)
    );

    // Configuration registers; drop data bits above each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_range_sel   <= 2'd3;
            r_cfg.gyro_range_sel    <= 2'd3;
            r_cfg.cross_axis_factor <= '0;
        end else if (i_cfg_valid) begin
            case (imu_ffd_pkg::t_cfg_idx'(i_cfg_index))
                imu_ffd_pkg::CFG_ACCEL_RANGE: begin
                    r_cfg.accel_range_sel <= i_cfg_data[1:0];
                end
                imu_ffd_pkg::CFG_GYRO_RANGE: begin
                    r_cfg.gyro_range_sel <= i_cfg_data[1:0];
                end
                imu_ffd_pkg::CFG_CROSS_FACTOR: begin
                    r_cfg.cross_axis_factor <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register payload: hold until the next transfer.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_data <= s_axis_tdata;
        end
    end

    // Pipeline control and the held stores, which are the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_accel     <= '0;
            r_gyro      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_flags <= n_flags;
                    r_accel <= n_accel;
                    r_gyro  <= n_gyro;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_gyro, r_accel};
    assign m_axis_tuser  = r_flags;

endmodule

FILE: sv/imu_ffd_checker.sv
`include "imu_fifo_frame_decoder_assert.svh"

module imu_ffd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [imu_ffd_pkg::OUT_DW-1:0]  m_axis_tdata,
    input logic [2:0]                      m_axis_tuser
);

    // a stalled result keeps both flags and data
    `IMU_FFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // an empty result register never blocks the input
    `IMU_FFD_ASSERT_NOW(a_in_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input blocked with no result pending")

    // a skipped frame refreshes neither section
    `IMU_FFD_ASSERT_NOW(a_skip_flags, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == 2'b00, "skipped frame marked fresh")

    // held data changes only when a new result enters
    `IMU_FFD_ASSERT_NEXT(a_data_quiet, i_clk, i_rst_n, !m_axis_tvalid, $stable(m_axis_tdata) || m_axis_tvalid, "held data changed with no result")

endmodule

bind imu_fifo_frame_decoder imu_ffd_checker u_imu_ffd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
